[design/cbr_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic bisection root package
// Request and response types, sign code and sequencer states shared by the
// cubic bisection root unit and its sign evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbr_pkg;

  // Word width of the fixed-point operands (fixed by the request format).
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned TOL_BITS  = WORD_BITS - 1;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] left_end;
    logic signed [WORD_BITS-1:0] right_end;
    logic        [TOL_BITS-1:0]  tolerance;
  } req_t;

  typedef struct packed {
    logic                        status;
    logic signed [WORD_BITS-1:0] root;
    logic                        exact_zero;
  } rsp_t;

  // Sign of the cubic: zero flag dominates, otherwise neg selects - or +.
  typedef struct packed {
    logic zero;
    logic neg;
  } sign_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN_A,
    ST_SIGN_B,
    ST_DIFF,
    ST_MID,
    ST_SIGN_C
  } state_e;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_NA    = 1'b1;

endpackage : cbr_pkg

`default_nettype wire

[design/cbr_sign_unit.sv]
// ----------------------------------------------------------------------------
// Cubic sign evaluator
// Exact sign of (x-1)(x-2)(x-3) at a fixed-point point, by compares against one, two and three.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_sign_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic signed [cbr_pkg::WORD_BITS-1:0] x_i,
  output cbr_pkg::sign_t                       sign_o
);
  import cbr_pkg::*;

  // Wide enough for the word and for 3 << FRAC_BITS, plus a sign bit.
  localparam int unsigned XW = ((WORD_BITS > FRAC_BITS + 2) ? WORD_BITS : FRAC_BITS + 2) + 1;
  localparam logic signed [XW-1:0] ONE_C   = XW'(64'd1 << FRAC_BITS);
  localparam logic signed [XW-1:0] TWO_C   = XW'(64'd2 << FRAC_BITS);
  localparam logic signed [XW-1:0] THREE_C = XW'(64'd3 << FRAC_BITS);

  logic signed [XW-1:0] x_ext;

  assign x_ext = {{(XW-WORD_BITS){x_i[WORD_BITS-1]}}, x_i};

  // Below one: three negative factors. Between two and three: one negative.
  always_comb begin
    sign_o.zero = (x_ext == ONE_C) || (x_ext == TWO_C) || (x_ext == THREE_C);
    sign_o.neg  = (x_ext < ONE_C) || ((x_ext > TWO_C) && (x_ext < THREE_C));
  end

endmodule : cbr_sign_unit

`default_nettype wire

[design/cubic_bisection_root_unit.sv]
// ----------------------------------------------------------------------------
// Cubic bisection root unit
// Bisection search for a root of x^3 - 6x^2 + 11x - 6 on a fixed-point span.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i (left_end, right_end, tolerance, all with
//   FRAC_BITS fraction bits) and pulse start; the request is taken on a
//   clock edge with start high and busy low. busy stays high until the
//   result has been formed.
//   Result channel: done_o is high for exactly one cycle with rsp_o valid.
//   The receiver cannot stall; a result not taken in that cycle is lost.
//   Sequence: the signs at both ends are evaluated first, and the request
//   ends as not applicable when they agree; otherwise the unit runs up to
//   about 33 halving steps for a 32-bit span, ending early when the
//   midpoint is an exact root. Each step runs through the states
//   of the sequencer for span difference, midpoint add with the stop tests,
//   and a sign evaluation on the one shared compare unit.
//   One request at a time; a new start may come in the cycle done_o shows.
//   Reset (rst_ni low) returns the sequencer to idle and drops any pending
//   result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bisection_root_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cbr_pkg::req_t req_i,
  output logic          done_o,
  output cbr_pkg::rsp_t rsp_o
);
  import cbr_pkg::*;

  // Difference of two words needs one extra bit.
  localparam int unsigned DW = WORD_BITS + 1;

  state_e state_q, state_d;

  logic signed [WORD_BITS-1:0] a_q, a_d;
  logic signed [WORD_BITS-1:0] b_q, b_d;
  logic signed [WORD_BITS-1:0] c_q, c_d;
  logic signed [DW-1:0]        diff_q, diff_d;
  logic        [TOL_BITS-1:0]  tol_q, tol_d;
  sign_t                       sa_q, sa_d;
  logic                        iter_q, iter_d;
  logic                        done_q, done_d;
  rsp_t                        rsp_q, rsp_d;

  // Shared sign evaluator and its operand select.
  logic signed [WORD_BITS-1:0] sgn_x;
  sign_t                       sgn;

  // Midpoint arithmetic.
  logic signed [DW-1:0]        a_ext;
  logic signed [DW-1:0]        half_sum;
  logic signed [DW-1:0]        half;
  logic signed [WORD_BITS-1:0] c_new;
  logic                        wide;

  cbr_sign_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sign (
    .x_i   (sgn_x),
    .sign_o(sgn)
  );

  // Halve the span toward zero: add one before the shift when negative.
  assign a_ext    = {a_q[WORD_BITS-1], a_q};
  assign half_sum = diff_q + {{(DW-1){1'b0}}, diff_q[DW-1]};
  assign half     = half_sum >>> 1;
  assign c_new    = WORD_BITS'(a_ext + half);
  assign wide     = diff_q > $signed({2'b00, tol_q});

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    diff_d  = diff_q;
    tol_d   = tol_q;
    sa_d    = sa_q;
    iter_d  = iter_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;

    case (state_q)
      ST_SIGN_A: sgn_x = a_q;
      ST_SIGN_B: sgn_x = b_q;
      default:   sgn_x = c_q;
    endcase

    case (state_q)
      ST_IDLE: begin
        // Capture the request.
        if (start) begin
          a_d     = req_i.left_end;
          b_d     = req_i.right_end;
          tol_d   = req_i.tolerance;
          iter_d  = 1'b0;
          state_d = ST_SIGN_A;
        end
      end
      ST_SIGN_A: begin
        sa_d    = sgn;
        state_d = ST_SIGN_B;
      end
      ST_SIGN_B: begin
        // Same nonzero sign at both ends: no bracket, report not applicable.
        if (!sa_q.zero && !sgn.zero && (sa_q.neg == sgn.neg)) begin
          rsp_d.status     = STATUS_NA;
          rsp_d.root       = '0;
          rsp_d.exact_zero = 1'b0;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d  = {b_q[WORD_BITS-1], b_q} - a_ext;
        state_d = ST_MID;
      end
      ST_MID: begin
        c_d = c_new;
        // Stop when the midpoint no longer moves or the span is narrow enough.
        if ((iter_q && (c_new == c_q)) || !wide) begin
          rsp_d.status     = STATUS_FOUND;
          rsp_d.root       = c_new;
          rsp_d.exact_zero = 1'b0;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_SIGN_C;
        end
      end
      ST_SIGN_C: begin
        iter_d = 1'b1;
        if (sgn.zero) begin
          // Exact root at the midpoint.
          rsp_d.status     = STATUS_FOUND;
          rsp_d.root       = c_q;
          rsp_d.exact_zero = 1'b1;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          // Sign change against the left end: keep the left half.
          if (!sa_q.zero && (sa_q.neg != sgn.neg)) begin
            b_d = c_q;
          end else begin
            a_d  = c_q;
            sa_d = sgn;
          end
          state_d = ST_DIFF;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    diff_q <= diff_d;
    tol_q  <= tol_d;
    sa_q   <= sa_d;
    rsp_q  <= rsp_d;
  end

endmodule : cubic_bisection_root_unit

`default_nettype wire
